// ===== rtl/core/bclt_pkg.sv =====
// Package for the buffer claim lock table: widths, command and status codes.
// No dependencies.
`default_nettype none
package bclt_pkg;
   localparam int BUFFERS     = 256;
   localparam int MAX_CLAIMS  = 16;
   localparam int READER_BITS = 8;
   localparam int GEN_BITS    = 32;
   localparam int IDX_BITS    = $clog2(BUFFERS);
   localparam int LOG_BITS    = (MAX_CLAIMS > 1) ? $clog2(MAX_CLAIMS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_CLAIMS + 1);
   localparam int ENTRY_BITS  = 1 + READER_BITS + 1 + GEN_BITS;
   localparam int LOGW_BITS   = IDX_BITS + 1;

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_PUBLISH = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BIND     = 2'd1;
   localparam logic [1:0] ST_POISON   = 2'd2;
   localparam logic [1:0] ST_BUSY     = 2'd3;

   typedef struct packed {
      logic                   writer;
      logic [READER_BITS-1:0] readers;
      logic                   poisoned;
      logic [GEN_BITS-1:0]    generation;
   } entry_type;
endpackage
`default_nettype wire

// ===== rtl/core/bclt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module bclt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/buffer_claim_lock_table.sv =====
// Top level of the buffer claim lock table: FSM around the entry table RAM
// and the claim log RAM. Depends on bclt_pkg and bclt_ram.
`default_nettype none
// Channel | Ports              | Direction | Handshake
// req     | req_*              | in        | req_valid / req_ready
// rsp     | rsp_*              | out       | rsp_valid / rsp_ready
// csr     | csr_wr_en, csr_*   | in        | write enable, no wait
//
// A word passes accept, table read, and modify and write back in turn; the
// single read port of the entry table sets this sequence. A failing acquire
// with logged claims starts a walk through the log in S_ULOG, then undoes
// each logged claim in S_UENT and S_UWR, and rereads the entry in S_DONE and S_EXEC.
// After reset a clearing pass writes all BUFFERS table entries, one per cycle,
// before the first word is taken. The response sits in an output register;
// the next word is accepted only once that response is taken, at the earliest
// in the cycle it is taken.
module buffer_claim_lock_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_buffer_index,
   input  wire logic        req_buffer_present,
   input  wire logic        req_write_claim,
   input  wire logic        req_last_claim,
   input  wire logic        req_publish_succeeded,
   input  wire logic        req_poison_on_failure,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_entry_poisoned,
   output      logic [31:0] rsp_entry_generation,
   output      logic [7:0]  rsp_entry_readers,
   output      logic        rsp_entry_writer,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_reject_poisoned
);
   import bclt_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_ULOG  = 3'd4;
   localparam logic [2:0] S_UENT  = 3'd5;
   localparam logic [2:0] S_UWR   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [IDX_BITS:0]   clr_ff, clr_in;
   logic                rej_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]          fail_ff, fail_in;
   logic [CNT_BITS-1:0] walk_ff, walk_in;
   logic [1:0]          cmd_ff;
   logic [7:0]          idx_ff;
   logic                pres_ff, wr_ff, last_ff, succ_ff, pois_ff;
   logic [LOGW_BITS-1:0] ulog_ff, ulog_in;
   logic [1:0]          hst_ff, hst_in;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   entry_type           rsp_entry_ff;
   logic                rsp_pois_ff;
   logic                rsp_load;
   logic [1:0]          rsp_st_in;
   entry_type           rsp_ent_in;
   logic                rsp_pois_in;
   // second pass through S_EXEC after a rollback: report only, change nothing
   logic                done_pass_ff;

   // entry table
   logic                t_we;
   logic [IDX_BITS-1:0] t_waddr, t_raddr;
   entry_type           t_wdata, t_rdata;
   // claim log
   logic                 l_we;
   logic [LOG_BITS-1:0]  l_waddr, l_raddr;
   logic [LOGW_BITS-1:0] l_wdata, l_rdata;

   bclt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(BUFFERS)) u_table (
      .clock, .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata));
   bclt_ram #(.WIDTH(LOGW_BITS), .DEPTH(MAX_CLAIMS)) u_log (
      .clock, .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(l_raddr), .rd_data(l_rdata));

   logic in_range, bound, take;
   entry_type ent_mod;
   logic [1:0] chk;
   assign in_range = ({{(IDX_BITS+1-8){1'b0}}, idx_ff} < (IDX_BITS+1)'(BUFFERS));
   assign bound    = pres_ff && in_range;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   // acquire checks in order
   always_comb begin
      if (!bound) chk = ST_BIND;
      else if (rej_ff && t_rdata.poisoned) chk = ST_POISON;
      else if (wr_ff ? (t_rdata.writer || t_rdata.readers != '0) : t_rdata.writer)
         chk = ST_BUSY;
      else if (!wr_ff && (&t_rdata.readers)) chk = ST_BUSY;
      else if (cnt_ff >= CNT_BITS'(MAX_CLAIMS)) chk = ST_BUSY;
      else chk = ST_OK;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cnt_in   = cnt_ff;
      fail_in  = fail_ff;
      walk_in  = walk_ff;
      ulog_in  = ulog_ff;
      hst_in   = hst_ff;
      t_we     = 1'b0;
      t_waddr  = idx_ff[IDX_BITS-1:0];
      t_wdata  = t_rdata;
      t_raddr  = idx_ff[IDX_BITS-1:0];
      l_we     = 1'b0;
      l_waddr  = cnt_ff[LOG_BITS-1:0];
      l_wdata  = {idx_ff[IDX_BITS-1:0], wr_ff};
      l_raddr  = walk_ff[LOG_BITS-1:0];
      ent_mod  = t_rdata;
      rsp_load = 1'b0;
      rsp_st_in = ST_OK;
      rsp_ent_in = t_rdata;
      rsp_pois_in = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff[IDX_BITS-1:0];
            t_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (IDX_BITS+1)'(BUFFERS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            t_raddr = req_buffer_index[IDX_BITS-1:0];
            if (take) state_in = S_READ;
         end
         S_READ: begin
            // table read in flight for the held word
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (done_pass_ff) begin
               // after rollback: report the reread entry with the stored status
               rsp_load    = 1'b1;
               rsp_st_in   = hst_ff;
               rsp_ent_in  = in_range ? t_rdata : '0;
               rsp_pois_in = (in_range && pres_ff) ? t_rdata.poisoned : 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_DONE;
               hst_in   = ST_OK;
               if (cmd_ff == CMD_ACQUIRE) begin
                  if (fail_ff != ST_OK) begin
                     hst_in = fail_ff;
                     if (last_ff) fail_in = ST_OK;
                  end else if (chk != ST_OK) begin
                     hst_in  = chk;
                     fail_in = last_ff ? ST_OK : chk;
                     walk_in = '0;
                     if (cnt_ff != '0) begin
                        state_in = S_ULOG;
                        l_raddr  = '0;
                     end
                  end else begin
                     if (wr_ff) ent_mod.writer = 1'b1;
                     else ent_mod.readers = t_rdata.readers + 1'b1;
                     t_we    = 1'b1;
                     t_wdata = ent_mod;
                     l_we    = 1'b1;
                     cnt_in  = last_ff ? '0 : cnt_ff + 1'b1;
                  end
               end else if ((cmd_ff == CMD_RELEASE || cmd_ff == CMD_PUBLISH) && bound) begin
                  if (wr_ff) begin
                     if (cmd_ff == CMD_PUBLISH) begin
                        if (succ_ff) ent_mod.generation = t_rdata.generation + 1'b1;
                        else if (pois_ff) ent_mod.poisoned = 1'b1;
                     end
                     ent_mod.writer = 1'b0;
                  end else if (t_rdata.readers != '0) begin
                     ent_mod.readers = t_rdata.readers - 1'b1;
                  end
                  t_we    = 1'b1;
                  t_wdata = ent_mod;
               end
               if (state_in == S_DONE) begin
                  rsp_load    = 1'b1;
                  rsp_st_in   = hst_in;
                  rsp_ent_in  = in_range ? (t_we ? ent_mod : t_rdata) : '0;
                  rsp_pois_in = (in_range && pres_ff) ? rsp_ent_in.poisoned : 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_ULOG: begin
            // log word arrives next cycle
            state_in = S_UENT;
         end
         S_UENT: begin
            ulog_in  = l_rdata;
            t_raddr  = l_rdata[LOGW_BITS-1:1];
            state_in = S_UWR;
         end
         S_UWR: begin
            t_waddr = ulog_ff[LOGW_BITS-1:1];
            if (ulog_ff[0]) ent_mod.writer = 1'b0;
            else if (t_rdata.readers != '0) ent_mod.readers = t_rdata.readers - 1'b1;
            t_we    = 1'b1;
            t_wdata = ent_mod;
            walk_in = walk_ff + 1'b1;
            l_raddr = walk_in[LOG_BITS-1:0];
            if (walk_in == cnt_ff || walk_ff == CNT_BITS'(MAX_CLAIMS - 1)) begin
               cnt_in   = '0;
               t_raddr  = idx_ff[IDX_BITS-1:0];
               state_in = S_DONE;
            end else begin
               state_in = S_UENT;
            end
         end
         S_DONE: begin
            // reread the addressed entry after rollback
            state_in = S_EXEC;
            hst_in   = hst_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rej_ff       <= 1'b0;
         cnt_ff       <= '0;
         fail_ff      <= ST_OK;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         done_pass_ff <= 1'b0;
      end else begin
         if (csr_wr_en) rej_ff <= csr_reject_poisoned;
         clr_ff       <= clr_in;
         walk_ff      <= walk_in;
         cnt_ff       <= cnt_in;
         state_ff     <= state_in;
         fail_ff      <= fail_in;
         done_pass_ff <= (state_ff == S_DONE);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ulog_ff <= ulog_in;
      hst_ff  <= hst_in;
      if (take) begin
         cmd_ff  <= req_command;
         idx_ff  <= req_buffer_index;
         pres_ff <= req_buffer_present;
         wr_ff   <= req_write_claim;
         last_ff <= req_last_claim;
         succ_ff <= req_publish_succeeded;
         pois_ff <= req_poison_on_failure;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_st_in;
         rsp_entry_ff  <= rsp_ent_in;
         rsp_pois_ff   <= rsp_pois_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_poisoned   = rsp_pois_ff;
   assign rsp_entry_generation = rsp_entry_ff.generation;
   assign rsp_entry_readers    = rsp_entry_ff.readers;
   assign rsp_entry_writer     = rsp_entry_ff.writer;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for buffer_claim_lock_table: claim words go in over req_*,
// checked against an in-bench lock table predictor. Depends on bclt_pkg and the RTL.
module tb;
   import bclt_pkg::*;

   typedef struct {
      logic [1:0] command;
      logic [7:0] index;
      logic       present;
      logic       write;
      logic       last;
      logic       succeeded;
      logic       poison;
   } claim_word_type;

   typedef struct {
      logic [1:0]  status;
      logic        poisoned;
      logic [31:0] generation;
      logic [7:0]  readers;
      logic        writer;
   } entry_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // DUT inputs, all known from time zero
   logic        req_valid = 1'b0;
   logic [1:0]  req_command = CMD_QUERY;
   logic [7:0]  req_buffer_index = '0;
   logic        req_buffer_present = 1'b0;
   logic        req_write_claim = 1'b0;
   logic        req_last_claim = 1'b0;
   logic        req_publish_succeeded = 1'b0;
   logic        req_poison_on_failure = 1'b0;
   logic        rsp_ready = 1'b0;
   logic        csr_wr_en = 1'b0;
   logic        csr_reject_poisoned = 1'b0;

   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_entry_poisoned;
   logic [31:0] rsp_entry_generation;
   logic [7:0]  rsp_entry_readers;
   logic        rsp_entry_writer;

   buffer_claim_lock_table u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_buffer_index      (req_buffer_index),
      .req_buffer_present    (req_buffer_present),
      .req_write_claim       (req_write_claim),
      .req_last_claim        (req_last_claim),
      .req_publish_succeeded (req_publish_succeeded),
      .req_poison_on_failure (req_poison_on_failure),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_entry_poisoned    (rsp_entry_poisoned),
      .rsp_entry_generation  (rsp_entry_generation),
      .rsp_entry_readers     (rsp_entry_readers),
      .rsp_entry_writer      (rsp_entry_writer),
      .csr_wr_en             (csr_wr_en),
      .csr_reject_poisoned   (csr_reject_poisoned)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Lock table predictor: own copy of every entry, the open batch log
   // and the sticky batch failure.
   // ---------------------------------------------------------------
   logic                   lt_writer [BUFFERS];
   logic [READER_BITS-1:0] lt_readers [BUFFERS];
   logic                   lt_poison [BUFFERS];
   logic [GEN_BITS-1:0]    lt_generation [BUFFERS];
   logic [IDX_BITS-1:0]    batch_log_index [MAX_CLAIMS];
   logic                   batch_log_write [MAX_CLAIMS];
   int                     batch_log_fill = 0;
   logic [1:0]             batch_fail = ST_OK;
   logic                   reject_poisoned_cfg = 1'b0;

   initial begin
      for (int i = 0; i < BUFFERS; i++) begin
         lt_writer[i] = 1'b0;
         lt_readers[i] = '0;
         lt_poison[i] = 1'b0;
         lt_generation[i] = '0;
      end
   end

   // Undo every claim logged in the open batch.
   task automatic roll_back_batch();
      for (int k = 0; k < batch_log_fill; k++) begin
         if (batch_log_write[k])
            lt_writer[batch_log_index[k]] = 1'b0;
         else if (lt_readers[batch_log_index[k]] != 0)
            lt_readers[batch_log_index[k]]--;
      end
      batch_log_fill = 0;
   endtask

   task automatic acquire_claim(input claim_word_type w, output logic [1:0] st);
      logic [1:0] fail;
      fail = ST_OK;
      if (batch_fail != ST_OK) begin
         // failed batch: repeat status until its last word
         st = batch_fail;
         if (w.last)
            batch_fail = ST_OK;
         return;
      end
      if (!w.present)
         fail = ST_BIND;
      else if (reject_poisoned_cfg && lt_poison[w.index])
         fail = ST_POISON;
      else if (w.write ? (lt_writer[w.index] || lt_readers[w.index] != 0)
                       : lt_writer[w.index])
         fail = ST_BUSY;
      else if (!w.write && lt_readers[w.index] == {READER_BITS{1'b1}})
         fail = ST_BUSY;
      else if (batch_log_fill >= MAX_CLAIMS)
         fail = ST_BUSY;
      st = fail;
      if (fail != ST_OK) begin
         roll_back_batch();
         batch_fail = w.last ? ST_OK : fail;
         return;
      end
      if (w.write)
         lt_writer[w.index] = 1'b1;
      else
         lt_readers[w.index]++;
      batch_log_index[batch_log_fill] = w.index;
      batch_log_write[batch_log_fill] = w.write;
      batch_log_fill++;
      if (w.last)
         batch_log_fill = 0;
   endtask

   task automatic predict_report(input claim_word_type w, output entry_report_type r);
      logic [1:0] st;
      st = ST_OK;
      if (w.command == CMD_ACQUIRE) begin
         acquire_claim(w, st);
      end else if ((w.command == CMD_RELEASE || w.command == CMD_PUBLISH) && w.present) begin
         if (w.write) begin
            if (w.command == CMD_PUBLISH) begin
               if (w.succeeded)
                  lt_generation[w.index]++;
               else if (w.poison)
                  lt_poison[w.index] = 1'b1;
            end
            lt_writer[w.index] = 1'b0;
         end else if (lt_readers[w.index] != 0) begin
            lt_readers[w.index]--;
         end
      end
      r.status = st;
      r.poisoned = w.present ? lt_poison[w.index] : 1'b1;
      r.generation = lt_generation[w.index];
      r.readers = lt_readers[w.index];
      r.writer = lt_writer[w.index];
   endtask

   // ---------------------------------------------------------------
   // Driver: present pending words with random gaps; predict on accept.
   // ---------------------------------------------------------------
   claim_word_type   pending_words[$];
   entry_report_type expected_reports[$];
   int               req_gap = 0;
   bit               req_burst = 1'b0;
   int               words_sent = 0;
   int               reports_seen = 0;
   int               mismatches = 0;

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   always @(posedge clock) begin
      entry_report_type r;
      int g;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && req_ready) begin
         predict_report(pending_words[0], r);
         expected_reports.push_back(r);
         void'(pending_words.pop_front());
         words_sent++;
         // switch between bursts without gaps and random gaps now and then
         if ($urandom_range(0, 40) == 0)
            req_burst <= ~req_burst;
         g = draw_gap(req_burst);
         if (g == 0 && pending_words.size() != 0) begin
            req_command <= pending_words[0].command;
            req_buffer_index <= pending_words[0].index;
            req_buffer_present <= pending_words[0].present;
            req_write_claim <= pending_words[0].write;
            req_last_claim <= pending_words[0].last;
            req_publish_succeeded <= pending_words[0].succeeded;
            req_poison_on_failure <= pending_words[0].poison;
         end else begin
            req_valid <= 1'b0;
            req_gap <= g;
         end
      end else if (!req_valid) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_words.size() != 0) begin
            req_command <= pending_words[0].command;
            req_buffer_index <= pending_words[0].index;
            req_buffer_present <= pending_words[0].present;
            req_write_claim <= pending_words[0].write;
            req_last_claim <= pending_words[0].last;
            req_publish_succeeded <= pending_words[0].succeeded;
            req_poison_on_failure <= pending_words[0].poison;
            req_valid <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random stalls on rsp_ready, compare against oldest report.
   // ---------------------------------------------------------------
   int  rsp_stall = 0;
   bit  rsp_burst = 1'b0;

   always @(posedge clock) begin
      int s;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            $error("unexpected response word, status %0d", rsp_status);
            mismatches++;
         end else begin
            if (rsp_status !== expected_reports[0].status) begin
               $error("status: expected %0d, got %0d", expected_reports[0].status, rsp_status);
               mismatches++;
            end
            if (rsp_entry_poisoned !== expected_reports[0].poisoned) begin
               $error("entry_poisoned: expected %0d, got %0d",
                      expected_reports[0].poisoned, rsp_entry_poisoned);
               mismatches++;
            end
            if (rsp_entry_generation !== expected_reports[0].generation) begin
               $error("entry_generation: expected %0d, got %0d",
                      expected_reports[0].generation, rsp_entry_generation);
               mismatches++;
            end
            if (rsp_entry_readers !== expected_reports[0].readers) begin
               $error("entry_readers: expected %0d, got %0d",
                      expected_reports[0].readers, rsp_entry_readers);
               mismatches++;
            end
            if (rsp_entry_writer !== expected_reports[0].writer) begin
               $error("entry_writer: expected %0d, got %0d",
                      expected_reports[0].writer, rsp_entry_writer);
               mismatches++;
            end
            void'(expected_reports.pop_front());
         end
         if ($urandom_range(0, 40) == 0)
            rsp_burst <= ~rsp_burst;
         s = draw_gap(rsp_burst);
         if (s != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= s;
         end
      end else if (!rsp_ready) begin
         if (rsp_stall != 0)
            rsp_stall <= rsp_stall - 1;
         else
            rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: covers the clearing pass after reset, a full rollback,
   // worst gaps and stalls, and the idle pause around a register write.
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic add_word(input logic [1:0] cmd, input logic [7:0] idx, input logic pres,
                           input logic wr, input logic last, input logic succ,
                           input logic poi);
      claim_word_type w;
      w.command = cmd;
      w.index = idx;
      w.present = pres;
      w.write = wr;
      w.last = last;
      w.succeeded = succ;
      w.poison = poi;
      pending_words.push_back(w);
   endtask

   // Hold until every word is answered, then let a full rollback drain.
   task automatic drain();
      while (pending_words.size() != 0 || expected_reports.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reject_poisoned(input logic v);
      drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_reject_poisoned <= v;
      reject_poisoned_cfg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_index();
      // most claims land on a small pool so they collide
      return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
   endfunction

   // Random batches of acquires, mostly followed by the matching releases
   // or publishes, plus stray queries and noise words.
   task automatic random_phase(input int count);
      claim_word_type batch [$];
      int n;
      while (count > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(1, 18);
            batch.delete();
            for (int i = 0; i < n; i++) begin
               add_word(CMD_ACQUIRE, pick_index(), $urandom_range(0, 19) != 0,
                        $urandom_range(0, 2) == 0, i == n - 1,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               batch.push_back(pending_words[$]);
            end
            count -= n;
            if ($urandom_range(0, 9) < 7) begin
               foreach (batch[i]) begin
                  add_word($urandom_range(0, 1) != 0 ? CMD_RELEASE : CMD_PUBLISH,
                           batch[i].index, $urandom_range(0, 19) != 0, batch[i].write,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                  count--;
               end
            end
         end else begin
            add_word(2'($urandom_range(0, 3)), pick_index(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            count--;
         end
         while (pending_words.size() > 64)
            @(posedge clock);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_reject_poisoned(1'b0);

      // writer then colliding reader, query, publish bumps generation
      add_word(CMD_ACQUIRE, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      add_word(CMD_ACQUIRE, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      add_word(CMD_QUERY,   8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_word(CMD_PUBLISH, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
      // failed publish poisons the top entry
      add_word(CMD_ACQUIRE, 8'd255, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      add_word(CMD_PUBLISH, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
      add_word(CMD_ACQUIRE, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      // absent binding on release is ignored, then a real release
      add_word(CMD_RELEASE, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_word(CMD_RELEASE, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      // absent binding fails the batch; the next acquire repeats the failure
      add_word(CMD_ACQUIRE, 8'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_word(CMD_QUERY,   8'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_word(CMD_ACQUIRE, 8'd4, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      // busy writer at the end of a batch rolls back the earlier claims
      add_word(CMD_ACQUIRE, 8'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_word(CMD_ACQUIRE, 8'd11, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_word(CMD_ACQUIRE, 8'd10, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      add_word(CMD_QUERY,   8'd11, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_word(CMD_PUBLISH, 8'd12, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);

      // reject poisoned entries
      write_reject_poisoned(1'b1);
      add_word(CMD_ACQUIRE, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      add_word(CMD_ACQUIRE, 8'd255, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);

      // log full: seventeenth claim of one batch fails busy
      for (int i = 0; i < 18; i++)
         add_word(CMD_ACQUIRE, 8'(20 + i), 1'b1, 1'b0, i == 17, 1'b0, 1'b0);

      // reader overflow: fill the count to its maximum, then one more
      for (int i = 0; i < 256; i++)
         add_word(CMD_ACQUIRE, 8'd7, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 256; i++)
         add_word(CMD_RELEASE, 8'd7, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);

      write_reject_poisoned(1'b0);
      random_phase(140);
      write_reject_poisoned(1'b1);
      random_phase(140);
      write_reject_poisoned(1'b0);
      random_phase(135);
      write_reject_poisoned(1'b1);
      random_phase(135);

      drain();
      $display("Covered %0d claim words over acquire, release, publish and query,", words_sent);
      $display("with rollbacks, full log, reader overflow and both poison settings.");
      if (mismatches == 0 && reports_seen == words_sent)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/bclt_pkg.sv
rtl/core/bclt_ram.sv
rtl/core/buffer_claim_lock_table.sv
tb/tb.sv
